// ===== rtl/skyline_rect_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// skyline rect allocator assertion macros
// shared concurrent assertion shorthands for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef SKYLINE_RECT_ALLOCATOR_UNIT_DEFINES_SVH
`define SKYLINE_RECT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define SRA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SRA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// sra_pkg
// sizes, codes and shared types of the skyline rect allocator
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_BLOCKS  = 256;

  localparam int COL_AW = $clog2(MAX_COLUMNS);
  localparam int BLK_AW = $clog2(MAX_BLOCKS);
  localparam int BLK_CW = BLK_AW + 1;
  // span / position arithmetic width
  localparam int SW     = ((COL_AW + 1) > 12 ? (COL_AW + 1) : 12) + 1;
  localparam int HW     = 11;

  localparam int HEIGHT_CAP = 1024;
  localparam int COL_MAX    = 2047;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_RESERVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic REG_ATLAS_W = 1'b0;
  localparam logic REG_ATLAS_H = 1'b1;

  typedef struct packed {
    logic [9:0]  left;
    logic [9:0]  top;
    logic [10:0] width;
    logic [10:0] height;
  } rect_t;

  typedef struct packed {
    logic [BLK_AW-1:0] rd_addr;
    logic              wr_en;
    logic              clr_en;
    logic [BLK_AW-1:0] wr_addr;
    rect_t             wr_data;
  } blk_cmd_t;

endpackage

// ===== rtl/sra_blocks.sv =====
// ----------------------------------------------------------------------------
// sra_blocks
// placed block list: record memory, valid bits and live count
// ----------------------------------------------------------------------------
`include "skyline_rect_allocator_unit_defines.svh"

module sra_blocks (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sra_pkg::blk_cmd_t                cmd_i,
  output sra_pkg::rect_t                   rd_data_o,
  output logic [sra_pkg::MAX_BLOCKS-1:0]   valid_o,
  output logic [sra_pkg::BLK_CW-1:0]       count_o
);
  import sra_pkg::*;

  rect_t                 mem [MAX_BLOCKS];
  rect_t                 rd_data_r;
  logic [MAX_BLOCKS-1:0] valid_r;
  logic [MAX_BLOCKS-1:0] valid_nxt;
  logic [BLK_CW-1:0]     count_r;
  logic [BLK_CW-1:0]     count_nxt;

  always_ff @(posedge clk) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
    rd_data_r <= mem[cmd_i.rd_addr];
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (cmd_i.wr_en) begin
      valid_nxt[cmd_i.wr_addr] = 1'b1;
      count_nxt = count_r + BLK_CW'(1);
    end else if (cmd_i.clr_en) begin
      valid_nxt[cmd_i.wr_addr] = 1'b0;
      count_nxt = count_r - BLK_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  assign rd_data_o = rd_data_r;
  assign valid_o   = valid_r;
  assign count_o   = count_r;

  `SRA_ASSERT_IMPL(a_count_matches, clk, rst_n, 1'b1, $countones(valid_r) == int'(count_r), "block count out of step with valid bits")
  `SRA_ASSERT_IMPL(a_set_free_slot, clk, rst_n, cmd_i.wr_en, !valid_r[cmd_i.wr_addr], "record written over a live slot")
  `SRA_ASSERT_IMPL(a_clr_live_slot, clk, rst_n, cmd_i.clr_en, valid_r[cmd_i.wr_addr], "release of a slot that is not live")

endmodule

// ===== rtl/skyline_rect_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// skyline_rect_allocator_unit
// skyline atlas allocator: places, frees and reserves rectangles
// ----------------------------------------------------------------------------
// One beat in, one beat out. After reset the column table is swept to zero,
// all MAX_COLUMNS (1024) columns with in_stall high; config writes are taken
// then. Each beat is worked by a small sequencer around one compare unit and
// a column memory with separate read and write ports and a registered read.
// Allocate tests window positions left to right, stopping a window at the
// first column no lower than the best so far, then raises the chosen columns
// and finds a free record slot. Free scans the record list for an exact
// match, clears the span, then walks all MAX_BLOCKS slots again and raises
// every column of a live record overlapping the span. Reserve searches for
// a free record slot. The next beat is taken as soon as the result sits in
// the output register, even while it waits on out_stall.
// ----------------------------------------------------------------------------
`include "skyline_rect_allocator_unit_defines.svh"

module skyline_rect_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  // config port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [9:0]  in_rect_left,
  input  logic [9:0]  in_rect_top,
  input  logic [10:0] in_rect_width,
  input  logic [10:0] in_rect_height,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [9:0]  out_placed_left,
  output logic [9:0]  out_placed_top
);
  import sra_pkg::*;

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;   // post-reset column sweep
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] A_RD   = 4'd2;   // alloc: fetch column of window
  localparam logic [3:0] A_CHK  = 4'd3;   // alloc: compare against best
  localparam logic [3:0] A_END  = 4'd4;   // alloc: height check
  localparam logic [3:0] A_WR   = 4'd5;   // alloc: raise window columns
  localparam logic [3:0] S_FIND = 4'd6;   // find free record slot
  localparam logic [3:0] F_RD   = 4'd7;   // free: fetch record
  localparam logic [3:0] F_CMP  = 4'd8;   // free: exact match test
  localparam logic [3:0] F_CLR  = 4'd9;   // free: zero the span
  localparam logic [3:0] R_RD   = 4'd10;  // rebuild: fetch record
  localparam logic [3:0] R_CHK  = 4'd11;  // rebuild: overlap setup
  localparam logic [3:0] R_COL  = 4'd12;  // rebuild: fetch column
  localparam logic [3:0] R_UPD  = 4'd13;  // rebuild: raise column
  localparam logic [3:0] S_FIN  = 4'd14;  // hand result to output register

  logic [3:0]  state_r, state_nxt;

  // config registers
  logic [10:0] atlas_width_r;
  logic [10:0] atlas_height_r;

  // loop counters and scan bookkeeping
  logic [SW-1:0]     x_r, x_nxt;
  logic [SW-1:0]     i_r, i_nxt;
  logic [BLK_AW-1:0] s_r, s_nxt;
  logic [HW-1:0]     best_r, best_nxt;
  logic [HW-1:0]     peak_r, peak_nxt;
  logic [SW-1:0]     bestx_r, bestx_nxt;
  logic              found_r, found_nxt;
  logic [SW-1:0]     lo_r, lo_nxt;
  logic [SW-1:0]     hi_r, hi_nxt;
  logic [SW-1:0]     ir_r, ir_nxt;
  logic [HW-1:0]     bot_r, bot_nxt;

  // request and result payload
  logic [1:0]  act_r, act_nxt;
  rect_t       req_r, req_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [9:0]  res_left_r, res_left_nxt;
  logic [9:0]  res_top_r, res_top_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r;
  logic [9:0]  out_left_r;
  logic [9:0]  out_top_r;
  logic        out_load;

  // column table
  logic [HW-1:0]     col_mem [MAX_COLUMNS];
  logic [HW-1:0]     col_rd_q;
  logic [COL_AW-1:0] col_raddr;
  logic              col_we;
  logic [COL_AW-1:0] col_waddr;
  logic [HW-1:0]     col_wdata;

  // block list
  blk_cmd_t              blk_cmd;
  rect_t                 blk_rd;
  logic [MAX_BLOCKS-1:0] blk_valid;
  logic [BLK_CW-1:0]     blk_count;

  // derived
  logic [SW-1:0] cols_s;
  logic [HW-1:0] rows;
  logic [SW-1:0] w_s;
  logic          list_full;
  logic          in_fire;
  logic [HW-1:0] peak_max;
  logic [SW-1:0] rec_end;
  logic [SW-1:0] rec_left;
  logic [11:0]   rec_bot;
  logic          last_slot;

  sra_blocks u_blocks (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (blk_cmd),
    .rd_data_o (blk_rd),
    .valid_o   (blk_valid),
    .count_o   (blk_count)
  );

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rd_q <= col_mem[col_raddr];
  end

  // atlas limits clipped to what the table holds
  assign cols_s = (SW'(atlas_width_r) > SW'(MAX_COLUMNS)) ? SW'(MAX_COLUMNS)
                                                          : SW'(atlas_width_r);
  assign rows   = (atlas_height_r > HW'(HEIGHT_CAP)) ? HW'(HEIGHT_CAP) : atlas_height_r;
  assign w_s    = SW'(req_r.width);

  assign list_full = (blk_count == BLK_CW'(MAX_BLOCKS));
  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // shared compare unit: running max of the window
  assign peak_max = (col_rd_q > peak_r) ? col_rd_q : peak_r;

  // record geometry as it comes out of the block list
  assign rec_left  = SW'(blk_rd.left);
  assign rec_end   = SW'(blk_rd.left) + SW'(blk_rd.width);
  assign rec_bot   = 12'(blk_rd.top) + 12'(blk_rd.height);
  assign last_slot = (s_r == BLK_AW'(MAX_BLOCKS - 1));

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    i_nxt          = i_r;
    s_nxt          = s_r;
    best_nxt       = best_r;
    peak_nxt       = peak_r;
    bestx_nxt      = bestx_r;
    found_nxt      = found_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    ir_nxt         = ir_r;
    bot_nxt        = bot_r;
    act_nxt        = act_r;
    req_nxt        = req_r;
    res_status_nxt = res_status_r;
    res_left_nxt   = res_left_r;
    res_top_nxt    = res_top_r;

    col_raddr = x_r[COL_AW-1:0];
    col_we    = 1'b0;
    col_waddr = x_r[COL_AW-1:0];
    col_wdata = '0;

    blk_cmd         = '0;
    blk_cmd.rd_addr = s_r;
    blk_cmd.wr_addr = s_r;
    blk_cmd.wr_data = req_r;

    case (state_r)
      S_CLR: begin
        col_we = 1'b1;
        if (x_r == SW'(MAX_COLUMNS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          x_nxt = x_r + SW'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_action;
          req_nxt.left   = in_rect_left;
          req_nxt.top    = in_rect_top;
          req_nxt.width  = in_rect_width;
          req_nxt.height = in_rect_height;
          res_status_nxt = ST_OK;
          res_left_nxt   = '0;
          res_top_nxt    = '0;
          x_nxt          = '0;
          i_nxt          = '0;
          s_nxt          = '0;
          peak_nxt       = '0;
          best_nxt       = rows;
          found_nxt      = 1'b0;
          case (in_action)
            ACT_ALLOC: begin
              if (in_rect_width == '0 || in_rect_height == '0 ||
                  SW'(in_rect_width) > cols_s || list_full) begin
                res_status_nxt = ST_NOSPACE;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = A_RD;
              end
            end
            ACT_FREE: begin
              state_nxt = F_RD;
            end
            ACT_RESERVE: begin
              if (list_full) begin
                res_status_nxt = ST_NOSPACE;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_FIND;
              end
            end
            default: begin
              // unused action: plain ok
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      A_RD: begin
        col_raddr = COL_AW'(x_r + i_r);
        state_nxt = A_CHK;
      end

      A_CHK: begin
        if (col_rd_q >= best_r || i_r + SW'(1) == w_s) begin
          if (col_rd_q < best_r) begin
            // whole window below the best so far
            best_nxt  = peak_max;
            bestx_nxt = x_r;
            found_nxt = 1'b1;
          end
          x_nxt    = x_r + SW'(1);
          i_nxt    = '0;
          peak_nxt = '0;
          if (x_r + SW'(1) + w_s > cols_s) begin
            state_nxt = A_END;
          end else begin
            state_nxt = A_RD;
          end
        end else begin
          peak_nxt  = peak_max;
          i_nxt     = i_r + SW'(1);
          state_nxt = A_RD;
        end
      end

      A_END: begin
        if (!found_r || (12'(best_r) + 12'(req_r.height)) > 12'(rows)) begin
          res_status_nxt = ST_NOSPACE;
          state_nxt      = S_FIN;
        end else begin
          i_nxt     = '0;
          state_nxt = A_WR;
        end
      end

      A_WR: begin
        col_we    = 1'b1;
        col_waddr = COL_AW'(bestx_r + i_r);
        col_wdata = best_r + req_r.height;
        i_nxt     = i_r + SW'(1);
        if (i_r + SW'(1) == w_s) begin
          req_nxt.left = bestx_r[9:0];
          req_nxt.top  = best_r[9:0];
          res_left_nxt = bestx_r[9:0];
          res_top_nxt  = best_r[9:0];
          s_nxt        = '0;
          state_nxt    = S_FIND;
        end
      end

      S_FIND: begin
        // a free slot exists: the count was checked on entry
        if (!blk_valid[s_r]) begin
          blk_cmd.wr_en = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          s_nxt = s_r + BLK_AW'(1);
        end
      end

      F_RD: begin
        state_nxt = F_CMP;
      end

      F_CMP: begin
        if (blk_valid[s_r] && blk_rd == req_r) begin
          blk_cmd.clr_en = 1'b1;
          lo_nxt         = rec_left;
          hi_nxt         = (rec_end > SW'(MAX_COLUMNS)) ? SW'(MAX_COLUMNS) : rec_end;
          x_nxt          = rec_left;
          state_nxt      = F_CLR;
        end else if (last_slot) begin
          res_status_nxt = ST_UNKNOWN;
          state_nxt      = S_FIN;
        end else begin
          s_nxt     = s_r + BLK_AW'(1);
          state_nxt = F_RD;
        end
      end

      F_CLR: begin
        if (x_r < hi_r) begin
          col_we = 1'b1;
          x_nxt  = x_r + SW'(1);
        end else begin
          s_nxt     = '0;
          state_nxt = R_RD;
        end
      end

      R_RD: begin
        state_nxt = R_CHK;
      end

      R_CHK: begin
        if (blk_valid[s_r]) begin
          x_nxt     = (rec_left > lo_r) ? rec_left : lo_r;
          ir_nxt    = (rec_end > hi_r) ? hi_r : rec_end;
          bot_nxt   = (rec_bot > 12'(COL_MAX)) ? HW'(COL_MAX) : rec_bot[HW-1:0];
          state_nxt = R_COL;
        end else if (last_slot) begin
          state_nxt = S_FIN;
        end else begin
          s_nxt     = s_r + BLK_AW'(1);
          state_nxt = R_RD;
        end
      end

      R_COL: begin
        if (x_r < ir_r) begin
          state_nxt = R_UPD;
        end else if (last_slot) begin
          state_nxt = S_FIN;
        end else begin
          s_nxt     = s_r + BLK_AW'(1);
          state_nxt = R_RD;
        end
      end

      R_UPD: begin
        if (col_rd_q < bot_r) begin
          col_we    = 1'b1;
          col_wdata = bot_r;
        end
        x_nxt     = x_r + SW'(1);
        state_nxt = R_COL;
      end

      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLR;
      x_r            <= '0;
      out_valid_r    <= 1'b0;
      atlas_width_r  <= 11'd1024;
      atlas_height_r <= 11'd1024;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ATLAS_W: atlas_width_r  <= cfg_wdata;
          REG_ATLAS_H: atlas_height_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    s_r          <= s_nxt;
    best_r       <= best_nxt;
    peak_r       <= peak_nxt;
    bestx_r      <= bestx_nxt;
    found_r      <= found_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    ir_r         <= ir_nxt;
    bot_r        <= bot_nxt;
    act_r        <= act_nxt;
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_left_r   <= res_left_nxt;
    res_top_r    <= res_top_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_left_r   <= res_left_r;
      out_top_r    <= res_top_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_placed_left = out_left_r;
  assign out_placed_top  = out_top_r;

  `SRA_ASSERT_IMPL(a_fail_no_place, clk, rst_n, out_valid && out_status != ST_OK, out_placed_left == '0 && out_placed_top == '0, "placement reported on a failed beat")
  `SRA_ASSERT_NEXT(a_beat_leaves_idle, clk, rst_n, in_fire, state_r != S_IDLE, "accepted beat did not start work")
  `SRA_ASSERT_IMPL(a_sweep_blocks_in, clk, rst_n, state_r == S_CLR, in_stall, "request taken during column sweep")
  `SRA_ASSERT_IMPL(a_reserve_no_col_write, clk, rst_n, act_r == ACT_RESERVE && state_r == S_FIND, !col_we, "reserve touched the column table")

endmodule

// ===== bench/tb_skyline_rect_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_skyline_rect_allocator_unit
// self-checking bench: a directed table, then random allocate, free and reserve
// traffic over several atlas sizes; every result beat is compared against an
// in-bench skyline model or a typed answer, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_skyline_rect_allocator_unit;
  import sra_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int HOLD_CYCLES  = 3000;

  // one result beat as seen on the output channel
  typedef struct {
    logic [1:0] status;
    logic [9:0] left;
    logic [9:0] top;
  } placement_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    logic [1:0]  act;
    logic [9:0]  l;
    logic [9:0]  t;
    logic [10:0] w;
    logic [10:0] h;
    bit          typed;
    logic [1:0]  st;
    logic [9:0]  pl;
    logic [9:0]  pt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_ATLAS_W;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_ALLOC;
  logic [9:0]  in_rect_left = '0;
  logic [9:0]  in_rect_top = '0;
  logic [10:0] in_rect_width = '0;
  logic [10:0] in_rect_height = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [9:0]  out_placed_left;
  logic [9:0]  out_placed_top;

  skyline_rect_allocator_unit dut (.*);

  always #4 clk = ~clk;

  // ---- skyline model state ----
  int          atlas_w_reg, atlas_h_reg;
  logic [10:0] sky[MAX_COLUMNS];
  rect_t       recs[MAX_BLOCKS];
  bit          rec_live[MAX_BLOCKS];
  int          rec_count;

  placement_t  pending_results[$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          act_cnt[4];
  int          ok_cnt = 0;
  logic        hold = 1'b0;   // long receiver hold-off
  logic        quiet = 1'b0;  // no idling on either side
  int          stall_left = 0;

  // first free slot takes the record; 0 when the list is full
  function automatic bit record_add(rect_t r);
    if (rec_count >= MAX_BLOCKS) return 0;
    for (int s = 0; s < MAX_BLOCKS; s++) begin
      if (!rec_live[s]) begin
        recs[s] = r;
        rec_live[s] = 1;
        rec_count++;
        return 1;
      end
    end
    return 0;
  endfunction

  // zero the freed span, then raise it again from the live records
  function automatic void sky_rebuild(rect_t b);
    int lo, hi, il, ir, bot;
    lo = b.left;
    hi = int'(b.left) + int'(b.width);
    if (hi > MAX_COLUMNS) hi = MAX_COLUMNS;
    for (int x = lo; x < hi; x++) sky[x] = '0;
    for (int s = 0; s < MAX_BLOCKS; s++) begin
      if (!rec_live[s]) continue;
      il = recs[s].left > lo ? int'(recs[s].left) : lo;
      ir = int'(recs[s].left) + int'(recs[s].width);
      if (ir > hi) ir = hi;
      bot = int'(recs[s].top) + int'(recs[s].height);
      if (bot > COL_MAX) bot = COL_MAX;
      for (int x = il; x < ir; x++)
        if (sky[x] < bot) sky[x] = bot[10:0];
    end
  endfunction

  // lowest window wins, leftmost on ties
  function automatic placement_t sky_alloc(int w, int h);
    placement_t p;
    int cols, rows, best, best_x, peak;
    bit found, fits;
    rect_t r;
    p = '{ST_NOSPACE, '0, '0};
    cols = atlas_w_reg > MAX_COLUMNS ? MAX_COLUMNS : atlas_w_reg;
    rows = atlas_h_reg > HEIGHT_CAP ? HEIGHT_CAP : atlas_h_reg;
    best = rows;
    best_x = 0;
    found = 0;
    if (w == 0 || h == 0 || w > cols || rec_count >= MAX_BLOCKS) return p;
    for (int x = 0; x + w <= cols; x++) begin
      peak = 0;
      fits = 1;
      for (int i = 0; i < w; i++) begin
        if (sky[x+i] >= best) begin
          fits = 0;
          break;
        end
        if (sky[x+i] > peak) peak = sky[x+i];
      end
      if (fits) begin
        best = peak;
        best_x = x;
        found = 1;
      end
    end
    if (!found || best + h > rows) return p;
    for (int i = 0; i < w; i++) sky[best_x+i] = 11'(best + h);
    r = '{best_x[9:0], best[9:0], w[10:0], h[10:0]};
    void'(record_add(r));
    p = '{ST_OK, best_x[9:0], best[9:0]};
    return p;
  endfunction

  function automatic placement_t allocator_step(logic [1:0] act, rect_t r);
    placement_t p;
    p = '{ST_OK, '0, '0};
    case (act)
      ACT_ALLOC: p = sky_alloc(r.width, r.height);
      ACT_FREE: begin
        p.status = ST_UNKNOWN;
        for (int s = 0; s < MAX_BLOCKS; s++) begin
          if (rec_live[s] && recs[s] == r) begin
            rec_live[s] = 0;
            rec_count--;
            sky_rebuild(r);
            p.status = ST_OK;
            break;
          end
        end
      end
      ACT_RESERVE: p.status = record_add(r) ? ST_OK : ST_NOSPACE;
      default: ;
    endcase
    return p;
  endfunction

  // ---- request side ----
  task automatic send_beat(logic [1:0] act, rect_t r, bit typed, placement_t typed_res);
    int gap;
    placement_t p;
    gap = quiet ? 0 : $urandom_range(13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_rect_left   <= r.left;
    in_rect_top    <= r.top;
    in_rect_width  <= r.width;
    in_rect_height <= r.height;
    do @(posedge clk); while (in_stall);
    // accepted on this edge: model the beat now
    p = allocator_step(act, r);
    if (typed) p = typed_res;
    pending_results = {pending_results, p};
    act_cnt[act]++;
    beats_sent++;
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ATLAS_W) atlas_w_reg = val & 'h7FF;
    else atlas_h_reg = val & 'h7FF;
  endtask

  // block is idle once every expected beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic rect_t live_record();
    int s;
    s = $urandom_range(MAX_BLOCKS - 1);
    for (int k = 0; k < MAX_BLOCKS; k++)
      if (rec_live[(s + k) % MAX_BLOCKS]) return recs[(s + k) % MAX_BLOCKS];
    return '{10'($urandom), 10'($urandom), 11'd1, 11'd1};
  endfunction

  // random traffic; allocate widths stay small so wide atlases stay quick
  task automatic random_phase(int n, int max_w);
    rect_t r;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      r = '{10'($urandom), 10'($urandom), 11'($urandom_range(1, 4)), 11'($urandom)};
      if (pick < 55) begin
        r.width  = 11'($urandom_range(1, max_w));
        r.height = 11'($urandom_range(1, 64));
        if ($urandom_range(19) == 0) r.width = 11'($urandom);
        if ($urandom_range(19) == 0) r.height = 11'($urandom);
        if ($urandom_range(29) == 0) r.width = '0;
        send_beat(ACT_ALLOC, r, 0, '{ST_OK, '0, '0});
      end else if (pick < 75) begin
        send_beat(ACT_FREE, live_record(), 0, '{ST_OK, '0, '0});
      end else if (pick < 80) begin
        send_beat(ACT_FREE, r, 0, '{ST_OK, '0, '0});
      end else if (pick < 95) begin
        if ($urandom_range(9) == 0) r.width = 11'($urandom);
        send_beat(ACT_RESERVE, r, 0, '{ST_OK, '0, '0});
      end else begin
        send_beat(2'd3, r, 0, '{ST_OK, '0, '0});
      end
    end
  endtask

  dir_row_t dir_rows[] = '{
    // zero-sized and too wide allocates
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd0,    11'd5,    1, ST_NOSPACE, 10'd0, 10'd0},
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd3,    11'd0,    1, ST_NOSPACE, 10'd0, 10'd0},
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd1025, 11'd1,    1, ST_NOSPACE, 10'd0, 10'd0},
    // first block on an empty atlas lands in the corner
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd1,    11'd1,    1, ST_OK,      10'd0, 10'd0},
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd1024, 11'd1,    0, ST_OK,      10'd0, 10'd0},
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd1,    11'd1024, 0, ST_OK,      10'd0, 10'd0},
    '{ACT_FREE,    10'd5,    10'd5,    11'd5,    11'd5,    1, ST_UNKNOWN, 10'd0, 10'd0},
    '{ACT_FREE,    10'd0,    10'd0,    11'd1,    11'd1,    0, ST_OK,      10'd0, 10'd0},
    // tall record hanging past the column table
    '{ACT_RESERVE, 10'd1000, 10'd1000, 11'd2047, 11'd2047, 1, ST_OK,      10'd0, 10'd0},
    '{ACT_RESERVE, 10'd0,    10'd0,    11'd1024, 11'd1024, 1, ST_OK,      10'd0, 10'd0},
    '{ACT_FREE,    10'd0,    10'd0,    11'd1024, 11'd1024, 0, ST_OK,      10'd0, 10'd0},
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd1,    11'd1,    0, ST_OK,      10'd0, 10'd0},
    '{2'd3,        10'd1023, 10'd1023, 11'd2047, 11'd2047, 1, ST_OK,      10'd0, 10'd0},
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd16,   11'd1000, 0, ST_OK,      10'd0, 10'd0},
    '{ACT_FREE,    10'd1000, 10'd1000, 11'd2047, 11'd2047, 0, ST_OK,      10'd0, 10'd0},
    '{ACT_FREE,    10'd0,    10'd1,    11'd1024, 11'd1,    0, ST_OK,      10'd0, 10'd0},
    '{ACT_RESERVE, 10'd1023, 10'd1023, 11'd1,    11'd1,    0, ST_OK,      10'd0, 10'd0},
    '{ACT_ALLOC,   10'd0,    10'd0,    11'd1024, 11'd1024, 0, ST_OK,      10'd0, 10'd0}
  };

  // ---- main sequence ----
  initial begin
    rect_t r;
    atlas_w_reg = 1024;
    atlas_h_reg = 1024;
    rec_count = 0;
    foreach (sky[i]) sky[i] = '0;
    foreach (rec_live[i]) rec_live[i] = 0;
    foreach (act_cnt[i]) act_cnt[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at the reset atlas size
    foreach (dir_rows[i]) begin
      r = '{dir_rows[i].l, dir_rows[i].t, dir_rows[i].w, dir_rows[i].h};
      send_beat(dir_rows[i].act, r, dir_rows[i].typed,
                '{dir_rows[i].st, dir_rows[i].pl, dir_rows[i].pt});
    end
    drain();

    // small atlas, no idling, receiver hold-off lands here
    write_reg(REG_ATLAS_W, 16);
    write_reg(REG_ATLAS_H, 64);
    quiet <= 1'b1;
    random_phase(30, 17);
    drain();
    quiet <= 1'b0;

    // smallest legal atlas
    write_reg(REG_ATLAS_W, 1);
    write_reg(REG_ATLAS_H, 1);
    random_phase(12, 2);
    drain();

    // registers beyond range clamp to the table size
    write_reg(REG_ATLAS_W, 2047);
    write_reg(REG_ATLAS_H, 2047);
    random_phase(10, 6);
    drain();

    // empty atlas: every allocate refused
    write_reg(REG_ATLAS_W, 0);
    write_reg(REG_ATLAS_H, 0);
    random_phase(6, 3);
    drain();

    write_reg(REG_ATLAS_W, 40);
    write_reg(REG_ATLAS_H, 200);
    random_phase(40, 41);
    drain();

    write_reg(REG_ATLAS_W, 8);
    write_reg(REG_ATLAS_H, 1024);
    random_phase(25, 9);
    drain();

    // wider atlas: release one record, then repeat one allocate
    write_reg(REG_ATLAS_W, 64);
    send_beat(ACT_FREE, live_record(), 0, '{ST_OK, '0, '0});
    send_beat(ACT_ALLOC, '{10'd0, 10'd0, 11'd2, 11'd3}, 0, '{ST_OK, '0, '0});
    send_beat(ACT_ALLOC, '{10'd0, 10'd0, 11'd2, 11'd3}, 0, '{ST_OK, '0, '0});
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d beats: %0d allocate, %0d free, %0d reserve, %0d unused action",
             beats_sent, act_cnt[0], act_cnt[1], act_cnt[2], act_cnt[3]);
    $display("checked %0d result beats, %0d ok, over eight atlas sizes",
             beats_checked, ok_cnt);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (beats_sent >= 24);
    @(posedge clk);
    hold <= 1'b1;
    for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
    hold <= 1'b0;
  end

  // ---- result side: stall, compare, retire ----
  always @(posedge clk) begin
    placement_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          e = pending_results.pop_front();
          beats_checked++;
          if (e.status == ST_OK) ok_cnt++;
          if (out_status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_status);
            fail_cnt++;
          end
          if (out_placed_left !== e.left) begin
            $error("placed_left: expected %0d, actual %0d", e.left, out_placed_left);
            fail_cnt++;
          end
          if (out_placed_top !== e.top) begin
            $error("placed_top: expected %0d, actual %0d", e.top, out_placed_top);
            fail_cnt++;
          end
        end
        stall_left = quiet ? 0 : $urandom_range(13);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold || (stall_left > 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
